/* rtl/elf_ppc_relocation_patcher_defines.svh */
// Assertion macros used by the relocation patcher top module.
`ifndef ELF_PPC_RELOCATION_PATCHER_DEFINES_SVH
`define ELF_PPC_RELOCATION_PATCHER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define EPPCR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("eppcr assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define EPPCR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("eppcr assertion failed");

`endif

/* rtl/eppcr_pkg.sv */
// Types, codes and helper functions of the relocation patcher.
`default_nettype none

package eppcr_pkg;

    // Relocation type codes.
    localparam logic [7:0] R_NONE      = 8'd0;
    localparam logic [7:0] R_ADDR32    = 8'd1;
    localparam logic [7:0] R_ADDR24    = 8'd2;
    localparam logic [7:0] R_ADDR16    = 8'd3;
    localparam logic [7:0] R_ADDR16_LO = 8'd4;
    localparam logic [7:0] R_ADDR16_HI = 8'd5;
    localparam logic [7:0] R_ADDR16_HA = 8'd6;
    localparam logic [7:0] R_REL24     = 8'd10;
    localparam logic [7:0] R_GLOB_DAT  = 8'd20;
    localparam logic [7:0] R_JMP_SLOT  = 8'd21;
    localparam logic [7:0] R_RELATIVE  = 8'd22;
    localparam logic [7:0] R_UADDR32   = 8'd24;
    localparam logic [7:0] R_UADDR16   = 8'd25;
    localparam logic [7:0] R_REL32     = 8'd26;

    // Store sizes.
    localparam logic [1:0] SIZE_NONE = 2'd0;
    localparam logic [1:0] SIZE_HALF = 2'd1;
    localparam logic [1:0] SIZE_WORD = 2'd2;

    // Status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_DATA = 2'd1;
    localparam logic [1:0] ST_NOT_SUPP = 2'd2;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_LOAD_DELTA   = 2'd0;
    localparam logic [1:0] REG_POOL_BASE    = 2'd1;
    localparam logic [1:0] REG_POOL_ISLANDS = 2'd2;

    // Trampoline beat indexes.
    localparam logic [2:0] BEAT_LIS    = 3'd0;
    localparam logic [2:0] BEAT_ORI    = 3'd1;
    localparam logic [2:0] BEAT_MTCTR  = 3'd2;
    localparam logic [2:0] BEAT_BCTR   = 3'd3;
    localparam logic [2:0] BEAT_BRANCH = 3'd4;

    localparam logic [31:0] LOW24_CHECK_MASK = 32'h3f800000;
    localparam logic [31:0] LOW24_KEEP_MASK  = 32'hfc000003;
    localparam logic [31:0] LOW24_FIELD_MASK = 32'h00ffffff;
    localparam logic [31:0] HALF_OVF_MASK    = 32'hffff8000;
    localparam logic [31:0] HALF_ROUND_BIT   = 32'h00008000;
    localparam logic [31:0] FAR_CHECK_MASK   = 32'hfe000000;
    localparam logic [31:0] BRANCH_OFF_MASK  = 32'h03fffffc;
    localparam logic [31:0] OP_B             = 32'h48000000;
    localparam logic [31:0] OP_LIS_R11       = 32'h3d600000;
    localparam logic [31:0] OP_ORI_R11       = 32'h616b0000;
    localparam logic [31:0] OP_MTCTR_R11     = 32'h7d6903a6;
    localparam logic [31:0] OP_BCTR          = 32'h4e800420;

    // One relocation entry after the address adds done at acceptance.
    typedef struct packed {
        logic [7:0]  func;
        logic [31:0] sa;      // symbol value plus addend
        logic [31:0] place;   // load delta plus place offset
        logic [31:0] rel;     // load delta plus addend
        logic [31:0] old_word;
        logic        eot;
    } item_t;

    // Island offered to the current far jump slot.
    typedef struct packed {
        logic        avail;
        logic [31:0] addr;
    } island_t;

    typedef struct packed {
        logic [31:0] addr;
        logic [31:0] data;
        logic [1:0]  size;
        logic [1:0]  status;
        logic        last;
    } result_t;

    function automatic logic fits_low24(input logic [31:0] v);
        return !(((v & LOW24_CHECK_MASK) != 32'd0) && ((~v & LOW24_CHECK_MASK) != 32'd0));
    endfunction

    function automatic logic [31:0] patch_low24(input logic [31:0] old_w,
                                                input logic [31:0] v);
        return (old_w & LOW24_KEEP_MASK) | ((v & LOW24_FIELD_MASK) << 2);
    endfunction

    function automatic logic far_branch(input logic [31:0] off);
        return ((off & FAR_CHECK_MASK) != 32'd0) && ((~off & FAR_CHECK_MASK) != 32'd0);
    endfunction

    function automatic logic [31:0] high_adj(input logic [31:0] v);
        logic [15:0] hi;
        hi = v[31:16] + {15'd0, ((v & HALF_ROUND_BIT) != 32'd0)};
        return {16'd0, hi};
    endfunction

endpackage

`default_nettype wire

/* rtl/eppcr_if.sv */
// Valid/ready stream interfaces for relocation entries and store results.
`default_nettype none

interface eppcr_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  func;
    logic [31:0] symbol_value;
    logic [31:0] addend;
    logic [31:0] place_offset;
    logic [31:0] old_word;
    logic        end_of_table;

    modport source (output valid, func, symbol_value, addend, place_offset, old_word,
                    end_of_table, input ready);
    modport sink (input valid, func, symbol_value, addend, place_offset, old_word,
                  end_of_table, output ready);
endinterface

interface eppcr_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] write_address;
    logic [31:0] write_data;
    logic [1:0]  write_size;
    logic [1:0]  status;
    logic        last;
    logic        table_done;

    modport source (output valid, write_address, write_data, write_size, status, last,
                    table_done, input ready);
    modport sink (input valid, write_address, write_data, write_size, status, last,
                  table_done, output ready);
endinterface

`default_nettype wire

/* rtl/eppcr_compute.sv */
// Combinational patch computation for one result beat of a relocation entry.
`default_nettype none

module eppcr_compute
    import eppcr_pkg::*;
(
    input  item_t       item,
    input  logic [2:0]  beat,
    input  island_t     island,
    output result_t     res
);

    logic [31:0] diff;
    logic [31:0] v24;
    logic [31:0] isl_off;
    logic        half_ovf;

    always_comb
    begin
        diff     = item.sa - item.place;
        v24      = ((item.func == R_ADDR24) ? item.sa : diff) >> 2;
        isl_off  = island.addr - item.place;
        half_ovf = ((item.sa & 32'hffff0000) != 32'd0) && ((~item.sa & HALF_OVF_MASK) != 32'd0);

        res        = '0;
        res.status = ST_OK;
        res.last   = 1'b1;

        case (item.func)
            R_NONE:
            begin
                res.size = SIZE_NONE;
            end
            R_ADDR32, R_GLOB_DAT, R_UADDR32:
            begin
                res.addr = item.place;
                res.data = item.sa;
                res.size = SIZE_WORD;
            end
            R_ADDR16, R_UADDR16:
            begin
                if (half_ovf)
                begin
                    res.status = ST_BAD_DATA;
                end
                else
                begin
                    res.addr = item.place;
                    res.data = {16'd0, item.sa[15:0]};
                    res.size = SIZE_HALF;
                end
            end
            R_ADDR16_LO:
            begin
                res.addr = item.place;
                res.data = {16'd0, item.sa[15:0]};
                res.size = SIZE_HALF;
            end
            R_ADDR16_HI:
            begin
                res.addr = item.place;
                res.data = {16'd0, item.sa[31:16]};
                res.size = SIZE_HALF;
            end
            R_ADDR16_HA:
            begin
                res.addr = item.place;
                res.data = high_adj(item.sa);
                res.size = SIZE_HALF;
            end
            R_ADDR24, R_REL24:
            begin
                if (fits_low24(v24))
                begin
                    res.addr = item.place;
                    res.data = patch_low24(item.old_word, v24);
                    res.size = SIZE_WORD;
                end
                else
                begin
                    res.status = ST_BAD_DATA;
                end
            end
            R_REL32:
            begin
                res.addr = item.place;
                res.data = diff;
                res.size = SIZE_WORD;
            end
            R_RELATIVE:
            begin
                res.addr = item.place;
                res.data = item.rel;
                res.size = SIZE_WORD;
            end
            R_JMP_SLOT:
            begin
                if (!far_branch(diff))
                begin
                    res.addr = item.place;
                    res.data = OP_B | (diff & BRANCH_OFF_MASK);
                    res.size = SIZE_WORD;
                end
                else if (!island.avail)
                begin
                    res.status = ST_NOT_SUPP;
                end
                else
                begin
                    // Four trampoline words, then the branch from the place to the island if it is in range.
                    res.size = SIZE_WORD;
                    res.last = 1'b0;
                    case (beat)
                        BEAT_LIS:
                        begin
                            res.addr = island.addr;
                            res.data = OP_LIS_R11 | {16'd0, item.sa[31:16]};
                        end
                        BEAT_ORI:
                        begin
                            res.addr = island.addr + 32'd4;
                            res.data = OP_ORI_R11 | {16'd0, item.sa[15:0]};
                        end
                        BEAT_MTCTR:
                        begin
                            res.addr = island.addr + 32'd8;
                            res.data = OP_MTCTR_R11;
                        end
                        BEAT_BCTR:
                        begin
                            res.addr = island.addr + 32'd12;
                            res.data = OP_BCTR;
                        end
                        default:
                        begin
                            res.last = 1'b1;
                            if (far_branch(isl_off))
                            begin
                                res.addr   = 32'd0;
                                res.data   = 32'd0;
                                res.size   = SIZE_NONE;
                                res.status = ST_NOT_SUPP;
                            end
                            else
                            begin
                                res.addr = item.place;
                                res.data = OP_B | (isl_off & BRANCH_OFF_MASK);
                            end
                        end
                    endcase
                end
            end
            default:
            begin
                res.status = ST_BAD_DATA;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/elf_ppc_relocation_patcher.sv */
// An accepted entry is held in the input register, then its first result in the output register,
// before rel_out can take that result.
// Throughput: one entry per cycle while rel_out is ready; a jump slot that takes an island emits five
// results, set by the beat counter that walks the trampoline words through one result path.
// Reset: rst_n clears valid flags, beat counter, islands taken and all configuration registers.
// Writes to the pool registers never clear the count of islands taken.
`default_nettype none
`include "elf_ppc_relocation_patcher_defines.svh"

module elf_ppc_relocation_patcher
    import eppcr_pkg::*;
#(
    parameter int MAX_ISLANDS = 4096
)
(
    input  logic        clk,
    input  logic        rst_n,
    eppcr_in_if.sink    rel_in,
    eppcr_out_if.source rel_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int UW = $clog2(MAX_ISLANDS + 1);
    localparam int CW = (UW > 13) ? UW : 13;

    logic [31:0]   load_delta_reg;
    logic [31:0]   pool_base_reg;
    logic [12:0]   pool_islands_reg;
    logic [UW-1:0] used_reg;

    logic          in_valid_reg;
    item_t         item_reg;
    logic [2:0]    beat_reg;
    logic          out_valid_reg;
    result_t       out_res_reg;
    logic          out_eot_reg;

    island_t       island;
    result_t       res;
    logic          advance;
    logic          cfg_write;
    logic          take_island;

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_delta_reg   <= '0;
            pool_base_reg    <= '0;
            pool_islands_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                REG_LOAD_DELTA:   load_delta_reg   <= pwdata;
                REG_POOL_BASE:    pool_base_reg    <= pwdata;
                REG_POOL_ISLANDS: pool_islands_reg <= pwdata[12:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_LOAD_DELTA:   prdata = load_delta_reg;
            REG_POOL_BASE:    prdata = pool_base_reg;
            REG_POOL_ISLANDS: prdata = {19'd0, pool_islands_reg};
            default:          prdata = 32'd0;
        endcase
    end

    // Next island from the pool; the count moves only when the item's last beat leaves.
    always_comb
    begin
        island.avail = (CW'(used_reg) < CW'(pool_islands_reg)) &&
                       (used_reg < UW'(MAX_ISLANDS));
        island.addr  = pool_base_reg + 32'({used_reg, 4'b0000});
    end

    eppcr_compute u_compute (
        .item   (item_reg),
        .beat   (beat_reg),
        .island (island),
        .res    (res)
    );

    assign advance      = in_valid_reg && (!out_valid_reg || rel_out.ready);
    assign rel_in.ready = !in_valid_reg || (advance && res.last);
    assign take_island  = advance && res.last && (item_reg.func == R_JMP_SLOT) &&
                          (beat_reg == BEAT_BRANCH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            beat_reg      <= BEAT_LIS;
            used_reg      <= '0;
        end
        else
        begin
            if (rel_in.ready)
            begin
                in_valid_reg <= rel_in.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                beat_reg      <= res.last ? BEAT_LIS : beat_reg + 3'd1;
            end
            else if (rel_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (take_island)
            begin
                used_reg <= used_reg + UW'(1);
            end
        end
    end

    // Payload registers; the address adds are done here so the result path stays short.
    always_ff @(posedge clk)
    begin
        if (rel_in.ready && rel_in.valid)
        begin
            item_reg.func     <= rel_in.func;
            item_reg.sa       <= rel_in.symbol_value + rel_in.addend;
            item_reg.place    <= load_delta_reg + rel_in.place_offset;
            item_reg.rel      <= load_delta_reg + rel_in.addend;
            item_reg.old_word <= rel_in.old_word;
            item_reg.eot      <= rel_in.end_of_table;
        end
        if (advance)
        begin
            out_res_reg <= res;
            out_eot_reg <= item_reg.eot;
        end
    end

    assign rel_out.valid         = out_valid_reg;
    assign rel_out.write_address = out_res_reg.addr;
    assign rel_out.write_data    = out_res_reg.data;
    assign rel_out.write_size    = out_res_reg.size;
    assign rel_out.status        = out_res_reg.status;
    assign rel_out.last          = out_res_reg.last;
    assign rel_out.table_done    = out_res_reg.last && out_eot_reg;

    `EPPCR_ASSERT_IMPL(a_used_bounded, clk, rst_n, 1'b1, used_reg <= UW'(MAX_ISLANDS))
    `EPPCR_ASSERT_IMPL(a_beat_only_jump, clk, rst_n, beat_reg != BEAT_LIS,
        in_valid_reg && (item_reg.func == R_JMP_SLOT))
    `EPPCR_ASSERT_NEXT(a_used_moves_on_take, clk, rst_n, !take_island, $stable(used_reg))

endmodule

`default_nettype wire
